[design/bst_pkg.sv]
// Shared types and codes for the bounded set table.
package bst_pkg;

	// Fixed widths of the command and response beats.
	localparam int ELEMENT_W = 16;
	localparam int MODE_W    = 2;
	localparam int COUNT_W   = 5;

	// Operation codes; the unused code behaves as a query.
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]    mode;
		logic [ELEMENT_W-1:0] element;
	} set_cmd_t;

	typedef struct packed {
		logic               was_member;
		logic [COUNT_W-1:0] count_after;
		logic               is_empty;
		logic               is_full;
	} set_rsp_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_SH_READ,
		ST_SH_WRITE,
		ST_FINISH
	} state_t;

endpackage

[design/bst_store.sv]
// Entry storage: one write port and one read port with registered read data.
module bst_store #(
	parameter int DEPTH  = 16,
	parameter int AW     = 4,
	parameter int DW     = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/bounded_set_table.sv]
// Top level of the bounded set table: sequencer, comparator and entry count.
//
// A set of up to CAPACITY distinct values kept packed in a small memory with
// a count. A command beat is taken when start is high and busy is low; one
// response beat follows, shown on rsp for exactly one cycle with done high,
// and it cannot be held off. The block walks the entries through the single
// memory read port and one equality comparator, a read state and a compare
// state per entry looked at; a delete then moves each later entry down one
// place, with a shift-read and a shift-write state per entry. On an empty
// set the walk is skipped and the item goes straight to the finish state.
// busy is low again in the cycle done is shown, so a new beat may be taken
// there. The memory needs no clearing after reset: only entries below the
// count are ever read.
module bounded_set_table
	import bst_pkg::*;
#(
	parameter int CAPACITY     = 16,
	parameter int ELEMENT_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  set_cmd_t cmd,
	output logic     busy,
	output logic     done,
	output set_rsp_t rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SB = (ELEMENT_BITS < ELEMENT_W) ? ELEMENT_BITS : ELEMENT_W;

	state_t state_q, state_d;

	logic [AW-1:0]     idx_q;
	logic [CW-1:0]     count_q;
	logic [SB-1:0]     value_q;
	logic [MODE_W-1:0] mode_q;
	logic              found_q;
	logic              done_q;
	set_rsp_t          rsp_q;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [SB-1:0] rd_data;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [SB-1:0] wr_data;

	logic          hit;
	logic          last;
	logic [CW-1:0] idx_inc;
	logic          shift_done;
	logic          do_insert;
	logic          do_delete;
	logic [CW-1:0] cnt_next;

	bst_store #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.DW    (SB)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Shared comparator and index arithmetic.
	always_comb begin
		idx_inc    = CW'(idx_q) + CW'(1);
		hit        = (rd_data == value_q);
		last       = (idx_inc == count_q);
		shift_done = (idx_inc >= count_q);
		do_insert  = (mode_q == MODE_INSERT) && !found_q && (count_q < CW'(CAPACITY));
		do_delete  = (mode_q == MODE_DELETE) && found_q;
		if (do_insert) begin
			cnt_next = count_q + CW'(1);
		end else if (do_delete) begin
			cnt_next = count_q - CW'(1);
		end else begin
			cnt_next = count_q;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (count_q == '0) ? ST_FINISH : ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (hit) begin
					state_d = (mode_q == MODE_DELETE) ? ST_SH_READ : ST_FINISH;
				end else if (last) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_SH_READ: begin
				state_d = shift_done ? ST_FINISH : ST_SH_WRITE;
			end
			ST_SH_WRITE: begin
				state_d = ST_SH_READ;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory port controls.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		case (state_q)
			ST_READ: begin
				rd_en = 1'b1;
			end
			ST_SH_READ: begin
				rd_en   = !shift_done;
				rd_addr = AW'(idx_inc);
			end
			ST_SH_WRITE: begin
				wr_en = 1'b1;
			end
			ST_FINISH: begin
				wr_en   = do_insert;
				wr_addr = AW'(count_q);
				wr_data = value_q;
			end
			default: begin
				rd_en = 1'b0;
				wr_en = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
			if (state_q == ST_IDLE && start) begin
				found_q <= 1'b0;
			end else if (state_q == ST_CMP && hit) begin
				found_q <= 1'b1;
			end
			if (state_q == ST_FINISH) begin
				count_q <= cnt_next;
			end
		end
	end

	// Item and response registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					value_q <= cmd.element[SB-1:0];
					mode_q  <= cmd.mode;
					idx_q   <= '0;
				end
			end
			ST_CMP: begin
				if (!hit && !last) begin
					idx_q <= AW'(idx_inc);
				end
			end
			ST_SH_WRITE: begin
				idx_q <= AW'(idx_inc);
			end
			ST_FINISH: begin
				rsp_q.was_member  <= found_q;
				rsp_q.count_after <= COUNT_W'(cnt_next);
				rsp_q.is_empty    <= (cnt_next == '0);
				rsp_q.is_full     <= (cnt_next == CW'(CAPACITY));
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef NO_ASSERTIONS
	// The response beat comes only once the sequencer is free again.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response shown while busy");

	// An accepted command always starts the sequencer.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted but sequencer idle");

	// The count never passes the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// A full set is never reported empty.
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.is_full) |-> !rsp.is_empty)
		else $error("response both full and empty");
`endif

endmodule
